// File: hdl/isadma_pkg.sv
// Shared types, codes and constants for the ISA DMA channel program sequencer.
package isadma_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_PREPARE = 2'd0;
   localparam logic [1:0] CMD_MASK    = 2'd1;
   localparam logic [1:0] CMD_UNMASK  = 2'd2;

   // 8237 register ports
   localparam logic [7:0] MASK_PORT     = 8'h0A;
   localparam logic [7:0] MODE_PORT     = 8'h0B;
   localparam logic [7:0] FLIPFLOP_PORT = 8'h0C;

   // Mode and mask bits
   localparam logic [7:0] MODE_SINGLE     = 8'h40;
   localparam logic [7:0] MODE_DEV_TO_MEM = 8'h04;
   localparam logic [7:0] MODE_MEM_TO_DEV = 8'h08;
   localparam logic [7:0] MASK_SET_BIT    = 8'h04;

   // Transfer limits
   localparam logic [31:0] MAX_LEN  = 32'h0001_0000;
   localparam logic [16:0] BOUNDARY = 17'h1_0000;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  channel;
      logic [31:0] phys_addr;
      logic [31:0] xfer_length;
      logic        to_memory;
   } req_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] port;
      logic [7:0] wdata;
      logic       accepted;
      logic       last_write;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_REJECT  = 2'd0,
      KIND_MASK    = 2'd1,
      KIND_UNMASK  = 2'd2,
      KIND_PREPARE = 2'd3
   } kind_type;

   // Classified command as it waits in the queue
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  channel;
      logic [23:0] addr;
      logic [15:0] count;
      logic        to_memory;
   } desc_type;

   // Page register port of each 8-bit channel
   function automatic logic [7:0] page_port(input logic [1:0] ch);
      logic [7:0] p;
      case (ch)
         2'd0:    p = 8'h87;
         2'd1:    p = 8'h83;
         2'd2:    p = 8'h81;
         default: p = 8'h82;
      endcase
      return p;
   endfunction

endpackage

// File: hdl/isadma_front.sv
// Front end: check a command and classify it into a queue descriptor.
module isadma_front (
   input  isadma_pkg::req_type  req,
   output isadma_pkg::desc_type desc
);
   import isadma_pkg::*;

   logic        ch_ok;
   logic        len_ok;
   logic        addr_ok;
   logic [16:0] end_offset;
   logic        bound_ok;
   logic        xfer_ok;
   kind_type    kind;

   assign ch_ok      = ~req.channel[2];
   assign len_ok     = (req.xfer_length != 32'd0) && (req.xfer_length <= MAX_LEN);
   assign addr_ok    = (req.phys_addr[31:24] == 8'd0);
   // end of the transfer within its 64 KiB page; only meaningful when len_ok
   assign end_offset = {1'b0, req.phys_addr[15:0]} + req.xfer_length[16:0];
   assign bound_ok   = (end_offset <= BOUNDARY);
   assign xfer_ok    = len_ok && addr_ok && bound_ok;

   always_comb begin
      unique case (req.command)
         CMD_PREPARE: kind = (ch_ok && xfer_ok) ? KIND_PREPARE : KIND_REJECT;
         CMD_MASK:    kind = ch_ok ? KIND_MASK : KIND_REJECT;
         CMD_UNMASK:  kind = ch_ok ? KIND_UNMASK : KIND_REJECT;
         default:     kind = KIND_REJECT;
      endcase
   end

   assign desc.kind      = kind;
   assign desc.channel   = req.channel[1:0];
   assign desc.addr      = req.phys_addr[23:0];
   assign desc.count     = req.xfer_length[15:0] - 16'd1;
   assign desc.to_memory = req.to_memory;

endmodule

// File: hdl/isadma_queue.sv
// Descriptor queue that decouples the front end from the write sequencer.
module isadma_queue #(
   parameter int DEPTH = isadma_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  isadma_pkg::desc_type push_desc,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output isadma_pkg::desc_type head_desc
);
   import isadma_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   desc_type      slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

endmodule

// File: hdl/isadma_back.sv
// Back end: step through the port writes of the head descriptor into an output register.
module isadma_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  isadma_pkg::desc_type head_desc,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output isadma_pkg::rsp_type  rsp_data
);
   import isadma_pkg::*;

   typedef enum logic [9:0] {
      STEP_MASK     = 10'b00_0000_0001,
      STEP_CLEAR_A  = 10'b00_0000_0010,
      STEP_MODE     = 10'b00_0000_0100,
      STEP_ADDR_LO  = 10'b00_0000_1000,
      STEP_ADDR_HI  = 10'b00_0001_0000,
      STEP_PAGE     = 10'b00_0010_0000,
      STEP_CLEAR_B  = 10'b00_0100_0000,
      STEP_COUNT_LO = 10'b00_1000_0000,
      STEP_COUNT_HI = 10'b01_0000_0000,
      STEP_UNMASK   = 10'b10_0000_0000
   } step_type;

   step_type   step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    cur;
   logic       load;
   logic       fire;
   logic [7:0] ch8;
   logic [7:0] aport;
   logic [7:0] cport;
   logic [7:0] mode;
   logic [7:0] mask_on;
   step_type   next_step;

   assign ch8     = {6'd0, head_desc.channel};
   assign aport   = {5'd0, head_desc.channel, 1'b0};
   assign cport   = {5'd0, head_desc.channel, 1'b1};
   assign mask_on = MASK_SET_BIT | ch8;
   assign mode    = MODE_SINGLE | (head_desc.to_memory ? MODE_DEV_TO_MEM : MODE_MEM_TO_DEV)
                    | ch8;

   // Output register takes a new write when empty or when its write leaves
   assign load = !rsp_valid_ff || !rsp_stall;
   assign fire = load && head_valid;

   always_comb begin
      cur.write_valid = 1'b1;
      cur.accepted    = 1'b1;
      cur.last_write  = 1'b0;
      cur.port        = MASK_PORT;
      cur.wdata       = mask_on;
      next_step       = STEP_MASK;
      unique case (step_ff)
         STEP_MASK: begin
            next_step = STEP_CLEAR_A;
            if (head_desc.kind == KIND_REJECT) begin
               cur.write_valid = 1'b0;
               cur.accepted    = 1'b0;
               cur.last_write  = 1'b1;
               cur.port        = 8'd0;
               cur.wdata       = 8'd0;
               next_step       = STEP_MASK;
            end else if (head_desc.kind == KIND_UNMASK) begin
               cur.wdata      = ch8;
               cur.last_write = 1'b1;
               next_step      = STEP_MASK;
            end else if (head_desc.kind == KIND_MASK) begin
               cur.last_write = 1'b1;
               next_step      = STEP_MASK;
            end
         end
         STEP_CLEAR_A: begin
            cur.port  = FLIPFLOP_PORT;
            cur.wdata = 8'd0;
            next_step = STEP_MODE;
         end
         STEP_MODE: begin
            cur.port  = MODE_PORT;
            cur.wdata = mode;
            next_step = STEP_ADDR_LO;
         end
         STEP_ADDR_LO: begin
            cur.port  = aport;
            cur.wdata = head_desc.addr[7:0];
            next_step = STEP_ADDR_HI;
         end
         STEP_ADDR_HI: begin
            cur.port  = aport;
            cur.wdata = head_desc.addr[15:8];
            next_step = STEP_PAGE;
         end
         STEP_PAGE: begin
            cur.port  = page_port(head_desc.channel);
            cur.wdata = head_desc.addr[23:16];
            next_step = STEP_CLEAR_B;
         end
         STEP_CLEAR_B: begin
            cur.port  = FLIPFLOP_PORT;
            cur.wdata = 8'd0;
            next_step = STEP_COUNT_LO;
         end
         STEP_COUNT_LO: begin
            cur.port  = cport;
            cur.wdata = head_desc.count[7:0];
            next_step = STEP_COUNT_HI;
         end
         STEP_COUNT_HI: begin
            cur.port  = cport;
            cur.wdata = head_desc.count[15:8];
            next_step = STEP_UNMASK;
         end
         STEP_UNMASK: begin
            cur.wdata      = ch8;
            cur.last_write = 1'b1;
            next_step      = STEP_MASK;
         end
         default: begin
            next_step = STEP_MASK;
         end
      endcase
   end

   assign pop          = fire && cur.last_write;
   assign step_in      = fire ? next_step : step_ff;
   assign rsp_valid_in = load ? head_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_MASK;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= cur;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_mid_has_head: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_MASK) |-> (head_valid && head_desc.kind == KIND_PREPARE))
      else $error("sequence in progress without a prepare descriptor");

   a_nonlast_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_write) |-> (rsp_ff.accepted && rsp_ff.write_valid))
      else $error("non-final result not an accepted write");

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accepted) |-> (rsp_ff.last_write && !rsp_ff.write_valid))
      else $error("rejected result carries a write or is not final");

endmodule

// File: hdl/isa_dma_channel_program_sequencer.sv
// Top level of the ISA DMA channel program sequencer.
//
// Each request transaction is a command (prepare, mask, unmask) for an 8-bit 8237 channel
// 0..3; the block answers with the byte-port writes that program the channel, one response
// transaction per cycle while not stalled, the final one flagged by last_write. A prepare
// that passes its checks (channel below 4, length 1..65536, address below 16 MiB, no
// 64 KiB crossing) gives ten writes: mask, flip-flop clear, mode, address low/high, page,
// flip-flop clear, count low/high (length - 1), unmask. Mask and unmask give one write to
// port 0x0A. Any rejected command gives a single response with write_valid and accepted
// low. The front end checks and classifies a request in the cycle it arrives and pushes
// it into a QUEUE_DEPTH-entry queue; it takes one request per cycle while the queue has
// room. The back-end sequencer emits one write per cycle into the response register
// unless the output stalls, so a prepare holds it for ten writes and any other command
// for one. A request passes through the queue and then the response register. There are
// no configuration registers; state is the queue, step register and response register.
module isa_dma_channel_program_sequencer #(
   parameter int QUEUE_DEPTH = isadma_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  isadma_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output isadma_pkg::rsp_type rsp_data
);
   import isadma_pkg::*;

   desc_type new_desc;
   desc_type head_desc;
   logic     queue_full;
   logic     head_valid;
   logic     push;
   logic     pop;

   // Classify the incoming command
   isadma_front u_front (
      .req  (req_data),
      .desc (new_desc)
   );

   // Hold off requests only while the queue is full
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   isadma_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (new_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // Expand the head descriptor into port writes
   isadma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the ISA DMA channel program sequencer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import isadma_pkg::*;

   // Command code with no meaning; the block must reject it
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;
   localparam logic [31:0] ADDR_LIMIT     = 32'h0100_0000;
   localparam logic [31:0] BLOCK_SIZE     = 32'h0001_0000;
   // Cycles to keep watching the response side once nothing is expected
   localparam int          SETTLE_CYCLES  = 20;
   localparam int          MAX_REPORTED   = 10;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Port writes still owed by the block, oldest first
   rsp_type expected_writes[$];
   int      mismatches = 0;

   // Idle controls shared by the test tasks and the response-side process
   bit      sender_gaps_on   = 1'b1;
   bit      receiver_gaps_on = 1'b1;
   int      hold_off_cycles  = 0;

   // Page register port of each 8-bit channel
   logic [7:0] page_reg_port[4] = '{8'h87, 8'h83, 8'h81, 8'h82};

   isa_dma_channel_program_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Expected port-write sequence
   // ------------------------------------------------------------------

   // True when the buffer is addressable by the 8237 and stays in one 64 KiB block
   function automatic bit transfer_fits(input logic [31:0] addr, input logic [31:0] len);
      logic [31:0] room;
      if (len == 32'd0 || len > MAX_LEN) return 1'b0;
      if (addr >= ADDR_LIMIT) return 1'b0;
      if (len > ADDR_LIMIT - addr) return 1'b0;
      room = BLOCK_SIZE - {16'h0000, addr[15:0]};
      return len <= room;
   endfunction

   function automatic void push_write(input logic [7:0] port, input logic [7:0] data,
                                      input logic last);
      rsp_type w;
      w.write_valid = 1'b1;
      w.port        = port;
      w.wdata       = data;
      w.accepted    = 1'b1;
      w.last_write  = last;
      expected_writes.push_back(w);
   endfunction

   // Append the responses that one command must produce
   function automatic void predict_port_writes(input req_type cmd);
      rsp_type     reject;
      logic [1:0]  ch;
      logic [7:0]  mode;
      logic [15:0] count;
      logic [7:0]  addr_port;
      logic [7:0]  count_port;
      ch         = cmd.channel[1:0];
      addr_port  = {5'd0, ch, 1'b0};
      count_port = {5'd0, ch, 1'b1};
      count      = 16'(cmd.xfer_length - 32'd1);
      mode       = MODE_SINGLE | (cmd.to_memory ? MODE_DEV_TO_MEM : MODE_MEM_TO_DEV)
                   | {6'd0, ch};
      if (cmd.channel < 3'd4 && cmd.command == CMD_MASK) begin
         push_write(MASK_PORT, MASK_SET_BIT | {6'd0, ch}, 1'b1);
      end else if (cmd.channel < 3'd4 && cmd.command == CMD_UNMASK) begin
         push_write(MASK_PORT, {6'd0, ch}, 1'b1);
      end else if (cmd.channel < 3'd4 && cmd.command == CMD_PREPARE
                   && transfer_fits(cmd.phys_addr, cmd.xfer_length)) begin
         push_write(MASK_PORT, MASK_SET_BIT | {6'd0, ch}, 1'b0);
         push_write(FLIPFLOP_PORT, 8'h00, 1'b0);
         push_write(MODE_PORT, mode, 1'b0);
         push_write(addr_port, cmd.phys_addr[7:0], 1'b0);
         push_write(addr_port, cmd.phys_addr[15:8], 1'b0);
         push_write(page_reg_port[ch], cmd.phys_addr[23:16], 1'b0);
         push_write(FLIPFLOP_PORT, 8'h00, 1'b0);
         push_write(count_port, count[7:0], 1'b0);
         push_write(count_port, count[15:8], 1'b0);
         push_write(MASK_PORT, {6'd0, ch}, 1'b1);
      end else begin
         // Any rejected command: one empty response that closes it
         reject            = '0;
         reject.last_write = 1'b1;
         expected_writes.push_back(reject);
      end
   endfunction

   // ------------------------------------------------------------------
   // Command builders
   // ------------------------------------------------------------------

   function automatic req_type make_command(input logic [1:0] code, input logic [2:0] ch,
                                            input logic [31:0] addr,
                                            input logic [31:0] len, input logic to_mem);
      req_type r;
      r.command     = code;
      r.channel     = ch;
      r.phys_addr   = addr;
      r.xfer_length = len;
      r.to_memory   = to_mem;
      return r;
   endfunction

   // Prepare for a valid channel whose buffer fits, or, when broken, fails one check
   function automatic req_type random_prepare(input bit broken);
      req_type     r;
      logic [31:0] room;
      r.command   = CMD_PREPARE;
      r.channel   = 3'($urandom_range(0, 3));
      r.to_memory = 1'($urandom);
      case ($urandom_range(0, 3))
         0: r.phys_addr = {8'h00, 8'($urandom), 16'h0000};
         1: r.phys_addr = {8'h00, 8'($urandom), 16'hFFFF - 16'($urandom_range(0, 15))};
         default: r.phys_addr = {8'h00, 24'($urandom)};
      endcase
      room = BLOCK_SIZE - {16'h0000, r.phys_addr[15:0]};
      if ($urandom_range(0, 3) == 0) begin
         r.xfer_length = room;
      end else begin
         r.xfer_length = $urandom_range(1, room);
      end
      if (broken) begin
         case ($urandom_range(0, 2))
            0: r.xfer_length = room + $urandom_range(1, 16);
            1: r.phys_addr[31:24] = 8'($urandom_range(1, 255));
            default: r.xfer_length = 32'd0;
         endcase
      end
      return r;
   endfunction

   // Mask or unmask on any channel, or fully random fields
   function automatic req_type random_other(input bit noise);
      req_type r;
      r.command     = noise ? 2'($urandom) : ($urandom_range(0, 1) ? CMD_MASK : CMD_UNMASK);
      r.channel     = 3'($urandom);
      r.phys_addr   = $urandom;
      r.xfer_length = $urandom;
      r.to_memory   = 1'($urandom);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one transaction after a random gap and hold it until it is taken
   task automatic send_command(input req_type cmd);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_port_writes(cmd);
   endtask

   // Drop valid and wait until every owed write has come back
   task automatic wait_until_drained(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall before each transaction, plus long hold-offs
   // ------------------------------------------------------------------
   initial begin : drive_rsp_stall
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            // Hold the output closed long enough for the request side to back up
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (!reset && rsp_valid && !rsp_stall) begin
            gap = receiver_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compare every accepted response with the oldest owed write
   always @(posedge clock) begin : check_writes
      rsp_type want;
      string   diff;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
               $display("%0t: unexpected response valid=%b port=%h data=%h acc=%b last=%b",
                        $realtime, rsp_data.write_valid, rsp_data.port, rsp_data.wdata,
                        rsp_data.accepted, rsp_data.last_write);
         end else begin
            want = expected_writes.pop_front();
            diff = "";
            if (rsp_data.write_valid !== want.write_valid) diff = {diff, " write_valid"};
            if (rsp_data.port !== want.port)               diff = {diff, " port"};
            if (rsp_data.wdata !== want.wdata)             diff = {diff, " wdata"};
            if (rsp_data.accepted !== want.accepted)       diff = {diff, " accepted"};
            if (rsp_data.last_write !== want.last_write)   diff = {diff, " last_write"};
            if (diff != "") begin
               mismatches++;
               if (mismatches <= MAX_REPORTED)
                  $display("%0t: mismatch in%s: expected %b/%h/%h/%b/%b got %b/%h/%h/%b/%b",
                           $realtime, diff, want.write_valid, want.port, want.wdata,
                           want.accepted, want.last_write, rsp_data.write_valid,
                           rsp_data.port, rsp_data.wdata, rsp_data.accepted,
                           rsp_data.last_write);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every command, both directions, and each edge of the transfer checks
   task automatic test_directed();
      send_command(make_command(CMD_MASK,    3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send_command(make_command(CMD_MASK,    3'd3, 32'h0, 32'h0, 1'b0));
      send_command(make_command(CMD_UNMASK,  3'd1, 32'h0, 32'h0, 1'b0));
      send_command(make_command(CMD_UNMASK,  3'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1));
      // Channels 4 and up are not 8-bit channels: reject
      send_command(make_command(CMD_MASK,    3'd4, 32'h0, 32'h1, 1'b0));
      send_command(make_command(CMD_UNMASK,  3'd7, 32'h0, 32'h1, 1'b0));
      send_command(make_command(CMD_UNUSED,  3'd0, 32'h0, 32'h1, 1'b1));
      // Shortest and longest transfers
      send_command(make_command(CMD_PREPARE, 3'd0, 32'h0000_0000, 32'd1, 1'b1));
      send_command(make_command(CMD_PREPARE, 3'd3, 32'h0000_0000, 32'h0001_0000, 1'b0));
      // Last byte of the 16 MiB window
      send_command(make_command(CMD_PREPARE, 3'd1, 32'h00FF_FFFF, 32'd1, 1'b1));
      // Ends exactly on a 64 KiB boundary, then one byte across it
      send_command(make_command(CMD_PREPARE, 3'd2, 32'h0012_3456, 32'h0000_CBAA, 1'b0));
      send_command(make_command(CMD_PREPARE, 3'd2, 32'h0012_3456, 32'h0000_CBAB, 1'b0));
      send_command(make_command(CMD_PREPARE, 3'd2, 32'h00AB_FFFF, 32'd1, 1'b1));
      // Length zero and one past the maximum
      send_command(make_command(CMD_PREPARE, 3'd0, 32'h0000_0000, 32'd0, 1'b1));
      send_command(make_command(CMD_PREPARE, 3'd0, 32'h0000_0000, 32'h0001_0001, 1'b0));
      // Address at and far beyond the 16 MiB limit
      send_command(make_command(CMD_PREPARE, 3'd1, 32'h0100_0000, 32'd1, 1'b1));
      send_command(make_command(CMD_PREPARE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      // Bad channel with a transfer that would otherwise pass
      send_command(make_command(CMD_PREPARE, 3'd5, 32'h0000_0000, 32'd16, 1'b0));
      send_command(make_command(CMD_PREPARE, 3'd1, 32'h0055_AA00, 32'h0000_0100, 1'b0));
      // Top and bottom length bits set
      send_command(make_command(CMD_PREPARE, 3'd0, 32'h0001_0000, 32'h8000_0001, 1'b1));
      wait_until_drained(SETTLE_CYCLES);
   endtask

   // Mostly well-formed prepares, with masks, near misses and noise mixed in
   task automatic test_random_mix(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)      send_command(random_prepare(1'b0));
         else if (pick < 75) send_command(random_other(1'b0));
         else if (pick < 85) send_command(random_prepare(1'b1));
         else                send_command(random_other(1'b1));
         // Pause the sender now and then until everything owed has come back
         if (i % 40 == 39) wait_until_drained(0);
      end
      wait_until_drained(SETTLE_CYCLES);
   endtask

   // Full rate on both sides: no gaps, no stalls
   task automatic test_back_to_back(input int count);
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) != 0) send_command(random_prepare(1'b0));
         else                           send_command(random_other(1'($urandom_range(0, 1))));
      end
      wait_until_drained(SETTLE_CYCLES);
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
   endtask

   // Close the output for a long stretch while requests keep coming
   task automatic test_backpressure(input int count);
      sender_gaps_on  = 1'b0;
      hold_off_cycles = 80;
      for (int i = 0; i < count; i++) begin
         if (i % 5 == 4) send_command(random_other(1'b0));
         else            send_command(random_prepare(1'b0));
      end
      wait_until_drained(SETTLE_CYCLES);
      sender_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(160);
      test_back_to_back(50);
      test_backpressure(30);

      if (mismatches == 0 && expected_writes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
hdl/isadma_pkg.sv
hdl/isadma_front.sv
hdl/isadma_queue.sv
hdl/isadma_back.sv
hdl/isa_dma_channel_program_sequencer.sv
tb/tb.sv
